@@ design/append_log_key_value_store_top_defines.svh @@
// assertion helpers used by the store controller
`ifndef APPEND_LOG_KEY_VALUE_STORE_TOP_DEFINES_SVH
`define APPEND_LOG_KEY_VALUE_STORE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define KVS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define KVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/kvs_pkg.sv @@
`timescale 1ns / 1ps

package kvs_pkg;

   // field widths
   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;

   // default log depth
   localparam int SLOTS_DEFAULT = 64;

   typedef logic [STAT_W-1:0] kvs_status_type;

   // result status codes
   localparam kvs_status_type ST_OK        = 2'd0;
   localparam kvs_status_type ST_COMPACTED = 2'd1;
   localparam kvs_status_type ST_CLEARED   = 2'd2;
   localparam kvs_status_type ST_RESERVED  = 2'd3;

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } kvs_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              found;
      kvs_status_type    status;
   } kvs_rsp_type;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic        valid;
      kvs_rsp_type rsp;
   } kvs_result_type;

endpackage

@@ design/kvs_ram.sv @@
`timescale 1ns / 1ps

module kvs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/kvs_ctrl.sv @@
`timescale 1ns / 1ps
`include "append_log_key_value_store_top_defines.svh"

module kvs_ctrl #(
   parameter int SLOTS = kvs_pkg::SLOTS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request side
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  kvs_pkg::kvs_req_type                      req_payload,
   // finished result
   input  logic                                      out_free,
   output kvs_pkg::kvs_result_type                   result,
   // log memory
   output logic                                      wr_en,
   output logic [$clog2(SLOTS)-1:0]                  wr_addr,
   output logic [kvs_pkg::KEY_W+kvs_pkg::DATA_W-1:0] wr_data,
   output logic                                      rd_en,
   output logic [$clog2(SLOTS)-1:0]                  rd_addr,
   input  logic [kvs_pkg::KEY_W+kvs_pkg::DATA_W-1:0] rd_data
);

   localparam int AW      = $clog2(SLOTS);
   localparam int CW      = $clog2(SLOTS + 1);
   localparam int ENTRY_W = kvs_pkg::KEY_W + kvs_pkg::DATA_W;
   localparam logic [CW-1:0] LAST_IDX = CW'(SLOTS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_RESOLVE = 3'd2;
   localparam logic [2:0] S_DEL     = 3'd3;
   localparam logic [2:0] S_APPEND  = 3'd4;
   localparam logic [2:0] S_COMPACT = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [CW-1:0]               used_ff, used_in;
   logic [CW-1:0]               ra_ff, ra_in;
   logic                        pend_ff, pend_in;
   logic [AW-1:0]               pidx_ff, pidx_in;
   logic [CW-1:0]               wp_ff, wp_in;
   logic                        op_ff, op_in;
   logic [kvs_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kvs_pkg::DATA_W-1:0]  data_ff, data_in;
   logic                        hit_ff, hit_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [kvs_pkg::DATA_W-1:0]  hval_ff, hval_in;
   kvs_pkg::kvs_rsp_type        res_ff, res_in;

   logic [kvs_pkg::KEY_W-1:0]   rd_key;
   logic [kvs_pkg::DATA_W-1:0]  rd_val;
   logic [CW-1:0]               app_idx;
   logic                        reserved;

   assign rd_key   = rd_data[ENTRY_W-1 -: kvs_pkg::KEY_W];
   assign rd_val   = rd_data[kvs_pkg::DATA_W-1:0];
   assign app_idx  = (used_ff > LAST_IDX) ? LAST_IDX : used_ff;
   assign reserved = (req_payload.key == '0) || (req_payload.key == '1);
   assign req_stall = (state_ff != S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      ra_in        = ra_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      wp_in        = wp_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      hval_in      = hval_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = ra_ff[AW-1:0];
      result.valid = 1'b0;
      result.rsp   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_payload.opcode;
               key_in  = req_payload.key;
               data_in = req_payload.data;
               ra_in   = '0;
               pend_in = 1'b0;
               hit_in  = 1'b0;
               if (reserved) begin
                  res_in.read_value = (req_payload.opcode == kvs_pkg::OP_SET) ?
                                      '0 : req_payload.data;
                  res_in.found      = 1'b0;
                  res_in.status     = kvs_pkg::ST_RESERVED;
                  state_in          = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         // oldest-first search, one read issued per cycle
         S_SCAN: begin
            if (pend_ff && (rd_key == key_ff)) begin
               hit_in   = 1'b1;
               pos_in   = pidx_ff;
               hval_in  = rd_val;
               pend_in  = 1'b0;
               state_in = S_RESOLVE;
            end else if (ra_ff < used_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ra_ff[AW-1:0];
               ra_in   = ra_ff + CW'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            res_in.read_value = '0;
            res_in.found      = hit_ff;
            res_in.status     = kvs_pkg::ST_OK;
            if (op_ff == kvs_pkg::OP_GET) begin
               res_in.read_value = hit_ff ? hval_ff : data_ff;
               state_in          = S_DONE;
            end else if (hit_ff && (hval_ff == data_ff)) begin
               state_in = S_DONE;
            end else if (hit_ff) begin
               state_in = S_DEL;
            end else begin
               state_in = S_APPEND;
            end
         end
         // old slot gets the deleted marker
         S_DEL: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = {{kvs_pkg::KEY_W{1'b0}}, hval_ff};
            state_in = S_APPEND;
         end
         S_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = app_idx[AW-1:0];
            wr_data = {key_ff, data_ff};
            used_in = app_idx + CW'(1);
            if (app_idx == LAST_IDX) begin
               ra_in    = '0;
               pend_in  = 1'b0;
               wp_in    = '0;
               state_in = S_COMPACT;
            end else begin
               state_in = S_DONE;
            end
         end
         // live slots slide to the front while they are counted
         S_COMPACT: begin
            if (pend_ff && (rd_key != '0)) begin
               wr_en   = 1'b1;
               wr_addr = wp_ff[AW-1:0];
               wr_data = rd_data;
               wp_in   = wp_ff + CW'(1);
            end
            if (ra_ff < used_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ra_ff[AW-1:0];
               ra_in   = ra_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (wp_ff >= LAST_IDX) begin
                     used_in       = '0;
                     res_in.status = kvs_pkg::ST_CLEARED;
                  end else begin
                     used_in       = wp_ff;
                     res_in.status = kvs_pkg::ST_COMPACTED;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            result.valid = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ra_ff   <= ra_in;
      pidx_ff <= pidx_in;
      wp_ff   <= wp_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      data_ff <= data_in;
      hit_ff  <= hit_in;
      pos_ff  <= pos_in;
      hval_ff <= hval_in;
      res_ff  <= res_in;
   end

   `KVS_ASSERT_IMP(a_used_bound, clock, reset, state_ff == S_IDLE, used_ff <= LAST_IDX)
   `KVS_ASSERT_IMP(a_no_rw_clash, clock, reset, rd_en && wr_en, rd_addr != wr_addr)
   `KVS_ASSERT_IMP(a_compact_behind, clock, reset, state_ff == S_COMPACT && wr_en, wp_ff <= CW'(pidx_ff))
   `KVS_ASSERT_IMP(a_result_room, clock, reset, result.valid, out_free)
   `KVS_ASSERT_NEXT(a_take_leaves_idle, clock, reset, state_ff == S_IDLE && req_valid, state_ff != S_IDLE)

endmodule

@@ design/append_log_key_value_store_top.sv @@
`timescale 1ns / 1ps
// Append-only key/value log with in-place compaction.
// Request channel (req_valid, req_stall, req_payload): opcode get or set, a 32-bit key and
// 32-bit data. A transfer takes place on a clock edge with req_valid high and req_stall low.
// Result channel (rsp_valid, rsp_stall, rsp_payload): one result per request, in order,
// carrying read_value, found and status.
// Items are handled one at a time. A get or set walks the log from the oldest slot through
// the read port of the log memory, one slot per cycle; a set that fills the last slot adds
// a compaction pass over the log. Reserved keys skip the search and go straight to the result.
// The finished result sits in an output register, so the next request transfer is taken
// while rsp_valid waits; with rsp_stall high the result holds until it is taken, and a
// second finished result waits inside the block until the register frees.
// Reset (synchronous, active high) empties the log by clearing the slot count; memory
// contents are not swept since slots past the count are never read.
module append_log_key_value_store_top #(
   parameter int SLOTS = kvs_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  kvs_pkg::kvs_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output kvs_pkg::kvs_rsp_type rsp_payload
);

   localparam int AW      = $clog2(SLOTS);
   localparam int ENTRY_W = kvs_pkg::KEY_W + kvs_pkg::DATA_W;

   kvs_pkg::kvs_result_type result;
   logic                    out_free;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [ENTRY_W-1:0]      wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [ENTRY_W-1:0]      rd_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   kvs_pkg::kvs_rsp_type    rsp_ff;

   // log memory, one slot per entry
   kvs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_log (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kvs_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_free    (out_free),
      .result      (result),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   // output register frees when empty or when its result transfers this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_ff <= result.rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
